/* src/arw_pkg.sv */
package arw_pkg;

    // Replay window size in bits, a power of two from 32 to 1024
    localparam int WINDOW_BITS = 128;
    localparam int WIN_IDX_W   = $clog2(WINDOW_BITS);

    localparam logic [31:0] WIN_SIZE  = 32'(WINDOW_BITS);
    // Largest window lower edge that does not wrap past zero
    localparam logic [31:0] LOWER_MAX = 32'd0 - WIN_SIZE;

    // Operation codes
    localparam logic OP_CHECK  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLAY_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESN_ENABLE    = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [31:0] seq_low;
    } t_in_item;

    typedef struct packed {
        logic        accept;
        logic        in_window;
        logic [31:0] seq_high;
    } t_out_item;

    typedef struct packed {
        logic capture;  // latch the incoming item
        logic execute;  // run the operation, commit state, load the result
    } t_dp_cmd;

endpackage

/* src/arw_ctrl.sv */
module arw_ctrl import arw_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        // the result register must be empty or emptying this cycle
        o_cmd.execute = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (o_cmd.execute) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_exec_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |=> r_out_valid)
        else $error("result not presented after execute");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |-> (!r_out_valid || !i_out_stall))
        else $error("execute would overwrite a pending result");

    a_wait_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && !o_cmd.execute) |-> (r_out_valid && i_out_stall))
        else $error("execute held back without a stalled result");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> !o_cmd.capture)
        else $error("second item captured before the first was executed");
`endif

endmodule

/* src/arw_dp.sv */
module arw_dp import arw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  t_in_item             i_in_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data,
    output t_out_item            o_out_item
);

    logic                   r_replay_enable;
    logic                   r_esn_enable;
    logic                   r_op;
    logic [31:0]            r_seq;
    logic [63:0]            r_edge_seq;
    logic [63:0]            n_edge_seq;
    logic [WINDOW_BITS-1:0] r_seen_map;
    logic [WINDOW_BITS-1:0] n_seen_map;
    logic [63:0]            r_tested_seq;
    logic [63:0]            n_tested_seq;
    logic                   r_tested_in_window;
    logic                   n_tested_in_window;
    t_out_item              r_out;
    t_out_item              n_out;

    logic [31:0]            edge_lo;
    logic [31:0]            edge_hi;
    logic [31:0]            commit_lo;
    logic [31:0]            diff;
    logic                   diff_small;
    logic [WINDOW_BITS-1:0] clr_mask;
    logic [WINDOW_BITS-1:0] set_mask;
    logic                   seen_bit;

    assign edge_lo    = r_edge_seq[31:0];
    assign edge_hi    = r_edge_seq[63:32];
    assign commit_lo  = r_tested_seq[31:0];
    assign diff       = commit_lo - edge_lo;
    assign diff_small = (diff < WIN_SIZE);
    assign seen_bit   = r_seen_map[r_seq[WIN_IDX_W-1:0]];
    assign o_out_item = r_out;

    // skipped positions edge+1 .. commit-1, taken modulo the window
    always_comb begin
        logic [WIN_IDX_W-1:0] off;
        off      = '0;
        set_mask = '0;
        set_mask[commit_lo[WIN_IDX_W-1:0]] = 1'b1;
        for (int i = 0; i < WINDOW_BITS; i++) begin
            off         = WIN_IDX_W'(i) - edge_lo[WIN_IDX_W-1:0];
            clr_mask[i] = (off != '0) && (off < diff[WIN_IDX_W-1:0]);
        end
    end

    always_comb begin
        logic [31:0] lower;
        logic [31:0] hi;
        logic        fresh;
        logic        acc;
        logic        in_win;

        lower  = edge_lo - WIN_SIZE + 32'd1;
        hi     = edge_hi;
        fresh  = 1'b0;
        acc    = 1'b1;
        in_win = 1'b0;

        n_edge_seq         = r_edge_seq;
        n_seen_map         = r_seen_map;
        n_tested_seq       = r_tested_seq;
        n_tested_in_window = r_tested_in_window;
        n_out              = r_out;

        if (r_esn_enable) begin
            if (lower <= LOWER_MAX) begin
                if (r_seq >= lower) begin
                    fresh = (r_seq > edge_lo);
                end else begin
                    hi    = edge_hi + 32'd1;
                    fresh = 1'b1;
                end
            end else begin
                if (r_seq >= lower) begin
                    hi = edge_hi - 32'd1;
                end else begin
                    fresh = (r_seq > edge_lo);
                end
            end
            if (!(fresh || !r_replay_enable)) begin
                in_win = 1'b1;
                acc    = !seen_bit;
            end
        end else begin
            if (!r_replay_enable) begin
                acc = 1'b1;
            end else if (r_seq == 32'd0) begin
                acc = 1'b0;
            end else if (r_seq > edge_lo) begin
                acc = 1'b1;
            end else if ((edge_lo - r_seq) >= WIN_SIZE) begin
                acc = 1'b0;
            end else begin
                in_win = 1'b1;
                acc    = !seen_bit;
            end
        end

        if (i_cmd.execute) begin
            if (r_op == OP_CHECK) begin
                n_tested_seq       = {hi, r_seq};
                n_tested_in_window = in_win;
                n_out.accept       = acc;
                n_out.in_window    = in_win;
                n_out.seq_high     = hi;
            end else begin
                if (!r_replay_enable) begin
                    n_edge_seq = r_tested_seq;
                end else begin
                    if (r_tested_in_window) begin
                        n_seen_map = r_seen_map | set_mask;
                    end else if (diff_small) begin
                        n_seen_map = (r_seen_map & ~clr_mask) | set_mask;
                        n_edge_seq = r_edge_seq + {32'd0, diff};
                    end else begin
                        n_seen_map = set_mask;
                        n_edge_seq = r_tested_seq;
                    end
                end
                n_out.accept    = 1'b1;
                n_out.in_window = r_tested_in_window;
                n_out.seq_high  = r_tested_seq[63:32];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_replay_enable    <= 1'b0;
            r_esn_enable       <= 1'b0;
            r_edge_seq         <= '0;
            r_seen_map         <= '0;
            r_tested_seq       <= '0;
            r_tested_in_window <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_REPLAY_ENABLE: r_replay_enable <= i_cfg_data;
                    CFG_ESN_ENABLE:    r_esn_enable    <= i_cfg_data;
                    default: ;
                endcase
            end
            r_edge_seq         <= n_edge_seq;
            r_seen_map         <= n_seen_map;
            r_tested_seq       <= n_tested_seq;
            r_tested_in_window <= n_tested_in_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_in_item.operation;
            r_seq <= i_in_item.seq_low;
        end
        r_out <= n_out;
    end

endmodule

/* src/anti_replay_window_unit.sv */
// Receive-side anti-replay window with optional 64-bit extended sequence numbers.
//
// Input channel (i_in_valid / o_in_stall, payload i_in_item): each transfer
// carries an operation and the low 32 bits of a sequence number. A check
// infers the high half, tests the seen-bitmap and remembers the number; an
// update commits the number remembered by the last check, sliding the window.
// Output channel (o_out_valid / i_out_stall, payload o_out_item): exactly one
// result per input transfer, in order.
// Config channel (i_cfg_valid / o_cfg_ready): index 0 replay_enable, index 1
// esn_enable. Ready is always high; write only while the block is idle.
//
// Timing: an item is latched on its transfer edge and evaluated in the evaluate
// state, where its result is loaded into the output register once that is free;
// no new item is taken until then, set by the single shared check/commit stage.
// If the receiver stalls, the result holds; one more item can be taken and waits
// in the evaluate stage until the output register frees up.
// Reset (synchronous, active low) clears the window edge, the bitmap, the
// remembered number and both config bits, and drops o_out_valid.
module anti_replay_window_unit import arw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data
);

    t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    // sequencing: latch, evaluate, hand off to the output register
    arw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // window state, bitmap, config bits and the result register
    arw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_item  (o_out_item)
    );

endmodule
